@@ src/seen_digest_dedup_filter_defines.svh @@
// assertion macros shared by the dedup filter rtl
`ifndef SEEN_DIGEST_DEDUP_FILTER_DEFINES_SVH
`define SEEN_DIGEST_DEDUP_FILTER_DEFINES_SVH

// same-cycle implication
`define SDDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sddf_pkg.sv @@
// types and constants of the digest dedup filter
`timescale 1ns / 1ps

package sddf_pkg;

   localparam int ENTRIES  = 8192;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int FILL_W   = $clog2(ENTRIES + 1);
   localparam int WORD_W   = 64;
   localparam int DIGEST_W = 4 * WORD_W;

   typedef struct packed {
      logic              req_type;
      logic [WORD_W-1:0] digest_w0;
      logic [WORD_W-1:0] digest_w1;
      logic [WORD_W-1:0] digest_w2;
      logic [WORD_W-1:0] digest_w3;
   } req_item_type;

   typedef struct packed {
      logic already_seen;
      logic was_inserted;
   } rsp_item_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
   } store_cmd_type;

   typedef struct packed {
      logic rd_valid;
      logic hit;
   } store_stat_type;

endpackage

@@ src/sddf_store.sv @@
// digest store memory with registered read and key compare
`timescale 1ns / 1ps

module sddf_store (
   input  logic                         clock,
   input  logic                         reset,
   input  sddf_pkg::store_cmd_type      cmd,
   input  logic [sddf_pkg::DIGEST_W-1:0] key,
   output sddf_pkg::store_stat_type     stat
);

   logic [sddf_pkg::DIGEST_W-1:0] store_mem [sddf_pkg::ENTRIES];
   logic [sddf_pkg::DIGEST_W-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic                          rd_valid_in;

   assign rd_valid_in = cmd.rd_en;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[cmd.wr_addr] <= key;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_comb begin
      stat.rd_valid = rd_valid_ff;
      stat.hit      = rd_valid_ff && (rd_data_ff == key);
   end

endmodule

@@ src/seen_digest_dedup_filter.sv @@
// Duplicate filter over 256-bit digests. Each item is a lookup, optionally followed by an
// insert when the digest is absent; one result comes back per item. Entries sit in one
// 8192-deep memory with a single read port, and the lookup reads the stored entries one
// per cycle, stopping at the first match. The search time grows with the number of stored
// entries, and a match ends the search early; the next item can be taken once the result
// is registered. Inserts fill the store from slot zero, then overwrite the oldest entry in
// ring order. One item is worked on at a time; the next item is taken while a finished
// result still waits in the output register.
`timescale 1ns / 1ps

`include "seen_digest_dedup_filter_defines.svh"

module seen_digest_dedup_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sddf_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sddf_pkg::rsp_item_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [sddf_pkg::FILL_W-1:0] FULL_LEVEL =
      sddf_pkg::FILL_W'(sddf_pkg::ENTRIES);
   localparam logic [sddf_pkg::IDX_W-1:0] LAST_SLOT =
      sddf_pkg::IDX_W'(sddf_pkg::ENTRIES - 1);

   logic [1:0]                     state_ff, state_in;
   logic [sddf_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [sddf_pkg::IDX_W-1:0]     oldest_ff, oldest_in;
   logic [sddf_pkg::FILL_W-1:0]    issue_ff, issue_in;
   logic [sddf_pkg::DIGEST_W-1:0]  key_ff, key_in;
   logic                           insert_ff, insert_in;
   logic                           seen_ff, seen_in;
   logic                           ins_ff, ins_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sddf_pkg::rsp_item_type         rsp_data_ff, rsp_data_in;
   sddf_pkg::store_cmd_type        cmd;
   sddf_pkg::store_stat_type       stat;

   sddf_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .key   (key_ff),
      .stat  (stat)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      issue_in     = issue_ff;
      key_in       = key_ff;
      insert_in    = insert_ff;
      seen_in      = seen_ff;
      ins_in       = ins_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = {req_data.digest_w3, req_data.digest_w2,
                            req_data.digest_w1, req_data.digest_w0};
               insert_in = req_data.req_type;
               issue_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               seen_in  = 1'b1;
               ins_in   = 1'b0;
               state_in = ST_DONE;
            end else if (issue_ff != fill_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = issue_ff[sddf_pkg::IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end else if (!stat.rd_valid) begin
               seen_in  = 1'b0;
               ins_in   = insert_ff;
               state_in = ST_DONE;
               if (insert_ff) begin
                  cmd.wr_en = 1'b1;
                  if (fill_ff != FULL_LEVEL) begin
                     cmd.wr_addr = fill_ff[sddf_pkg::IDX_W-1:0];
                     fill_in     = fill_ff + 1'b1;
                  end else begin
                     cmd.wr_addr = oldest_ff;
                     oldest_in   = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.already_seen = seen_ff;
               rsp_data_in.was_inserted = ins_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      key_ff      <= key_in;
      insert_ff   <= insert_in;
      seen_ff     <= seen_in;
      ins_ff      <= ins_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SDDF_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL_LEVEL, "fill over depth")
   `SDDF_ASSERT_SAME(a_ring_only_full, clock, reset, oldest_ff != '0, fill_ff == FULL_LEVEL, "ring moved before full")
   `SDDF_ASSERT_SAME(a_write_quiet, clock, reset, cmd.wr_en, state_ff == ST_SCAN && !stat.rd_valid && !cmd.rd_en, "write during read")
   `SDDF_ASSERT_NEXT(a_write_done, clock, reset, cmd.wr_en, state_ff == ST_DONE && ins_ff && !seen_ff, "write without insert result")
   `SDDF_ASSERT_SAME(a_rsp_exclusive, clock, reset, rsp_valid_ff, !(rsp_data_ff.already_seen && rsp_data_ff.was_inserted), "seen item inserted")

endmodule

@@ test/tb_seen_digest_dedup_filter.sv @@
// self-checking testbench of the digest dedup filter with a predictor, driver and monitor
`timescale 1ns / 1ps

module tb_seen_digest_dedup_filter;

   localparam int RANDOM_ITEMS  = 100;
   localparam int PHASE1_AT     = 50;
   localparam int PHASE2_AT     = 85;
   localparam int LONG_HOLD_AT  = 95;
   localparam int LONG_HOLD     = 600;
   localparam int SETTLE_CYCLES = 300;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct {
      sddf_pkg::req_item_type item;
      bit                     wait_drain;
   } queued_request_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sddf_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   sddf_pkg::rsp_item_type rsp_data;

   queued_request_type            digest_requests[$];
   sddf_pkg::rsp_item_type        awaited_verdicts[$];
   logic [sddf_pkg::DIGEST_W-1:0] seen_digests[sddf_pkg::ENTRIES];
   int unsigned                   stored_count;
   int unsigned                   ring_head;
   int                            total_requests;
   int                            accepted_count;
   int                            result_count;
   int                            mismatch_count;

   seen_digest_dedup_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // lookup over the stored digests, then insert when absent and asked for
   function automatic sddf_pkg::rsp_item_type judge_digest(sddf_pkg::req_item_type r);
      sddf_pkg::rsp_item_type        verdict;
      logic [sddf_pkg::DIGEST_W-1:0] d;
      int unsigned                   slot;
      d = {r.digest_w3, r.digest_w2, r.digest_w1, r.digest_w0};
      verdict = '0;
      for (int unsigned k = 0; k < stored_count; k++) begin
         if (seen_digests[k] == d) verdict.already_seen = 1'b1;
      end
      if (verdict.already_seen || !r.req_type) return verdict;
      if (stored_count < sddf_pkg::ENTRIES) begin
         slot = stored_count;
         stored_count++;
      end else begin
         slot = ring_head;
         ring_head = (ring_head + 1 == sddf_pkg::ENTRIES) ? 0 : ring_head + 1;
      end
      seen_digests[slot] = d;
      verdict.was_inserted = 1'b1;
      return verdict;
   endfunction

   function automatic int idle_pct(bit for_receiver);
      if (accepted_count < PHASE1_AT) return for_receiver ? 73 : 36;
      if (accepted_count < PHASE2_AT) return for_receiver ? 36 : 73;
      return 0;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_digest(logic kind, logic [sddf_pkg::DIGEST_W-1:0] d, bit wait_drain);
      queued_request_type q;
      q.item.req_type  = kind;
      q.item.digest_w0 = d[63:0];
      q.item.digest_w1 = d[127:64];
      q.item.digest_w2 = d[191:128];
      q.item.digest_w3 = d[255:192];
      q.wait_drain     = wait_drain;
      digest_requests.push_back(q);
      total_requests++;
   endtask

   // driver
   always @(posedge clock) begin
      queued_request_type nxt;
      logic               offer;
      offer = req_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_verdicts.push_back(judge_digest(req_data));
            accepted_count++;
            offer = 1'b0;
         end
         if (!offer && digest_requests.size() > 0 &&
             !(digest_requests[0].wait_drain && awaited_verdicts.size() > 0) &&
             $urandom_range(99) >= idle_pct(1'b0)) begin
            nxt = digest_requests.pop_front();
            req_data <= nxt.item;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      int hold_left;
      bit hold_done;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_count >= LONG_HOLD_AT) begin
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
   end

   // monitor
   always @(posedge clock) begin
      sddf_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (awaited_verdicts.size() == 0) begin
            report_mismatch($sformatf("result %b with no item outstanding", rsp_data));
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_data.already_seen !== want.already_seen)
               report_mismatch($sformatf("result %0d already_seen %b, predicted %b",
                  result_count, rsp_data.already_seen, want.already_seen));
            if (rsp_data.was_inserted !== want.was_inserted)
               report_mismatch($sformatf("result %0d was_inserted %b, predicted %b",
                  result_count, rsp_data.was_inserted, want.was_inserted));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [sddf_pkg::DIGEST_W-1:0] known[$];
      logic [sddf_pkg::DIGEST_W-1:0] d;
      logic                          kind;
      int                            pick;
      int                            w;
      reset = 1'b1;

      // directed: empty store, hits, repeats, partial matches per word
      queue_digest(1'b0, '0, 1'b0);
      queue_digest(1'b1, '0, 1'b0);
      queue_digest(1'b0, '0, 1'b0);
      queue_digest(1'b1, '0, 1'b0);
      queue_digest(1'b1, '1, 1'b0);
      queue_digest(1'b0, '1, 1'b0);
      for (int k = 0; k < 4; k++) begin
         d = '1;
         d[k*64 +: 64] = '0;
         queue_digest(1'b0, d, 1'b0);
         d = '0;
         d[k*64 +: 64] = '1;
         queue_digest(1'b1, d, 1'b0);
         known.push_back(d);
      end
      queue_digest(1'b0, known[2], 1'b0);
      queue_digest(1'b1, known[3], 1'b0);
      queue_digest(1'b0, {sddf_pkg::DIGEST_W{1'b1}} >> 1, 1'b0);
      queue_digest(1'b0, {{$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}}, 1'b0);
      known.push_back('0);
      known.push_back('1);

      // random: new inserts, repeats, near misses and plain lookups
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         d = {{$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}};
         kind = $urandom_range(1);
         if (pick < 40) begin
            kind = 1'b1;
         end else if (pick < 65) begin
            d = known[$urandom_range(known.size() - 1)];
         end else if (pick < 80) begin
            d = known[$urandom_range(known.size() - 1)] ^ (256'b1 << $urandom_range(255));
         end else if (pick < 95) begin
            kind = 1'b0;
         end else begin
            w = $urandom_range(3);
            d = known[$urandom_range(known.size() - 1)];
            d[w*64 +: 64] = d[w*64 +: 64] ^ {$urandom, $urandom};
         end
         if (kind) known.push_back(d);
         queue_digest(kind, d, n == 0 || n == 55);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_requests);
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
